// ===== sv/hashed_result_cache_lru_defines.svh =====
// Assertion macros used by the hashed result cache engine.
`ifndef HASHED_RESULT_CACHE_LRU_DEFINES_SVH
`define HASHED_RESULT_CACHE_LRU_DEFINES_SVH
`ifndef SYNTHESIS
`define HRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define HRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/hrc_pkg.sv =====
// Types, constants and helper functions of the hashed result cache.
`default_nettype none
package hrc_pkg;
	localparam int MAX_SIZE_LOG2_DEF = 12;
	localparam int PROBE_LIMIT_DEF = 8;
	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] CNT_C = 64'h9e3779b97f4a7c15;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR = 2'd2,
		OP_STATS = 2'd3
	} op_t;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_H5,
		ST_H6,
		ST_H7,
		ST_RD,
		ST_WAIT,
		ST_CHK,
		ST_WR,
		ST_CLR,
		ST_OUT,
		ST_INIT
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [63:0] key_mask;
		logic [5:0] key_count;
		logic [31:0] insert_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [31:0] found_value;
		logic evicted;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] insert_total;
		logic [31:0] evict_total;
	} res_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hffffffff) ? v : v + 32'd1;
	endfunction

	function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
		mul32 = {32'd0, a} * {32'd0, b};
	endfunction
endpackage
`default_nettype wire

// ===== sv/hrc_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module hrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== sv/hrc_front.sv =====
// Front end: accepts requests and queues them for the engine.
`default_nettype none
module hrc_front import hrc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_req,
	output logic q_valid,
	input wire logic q_pop,
	output req_t q_req
);
	req_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_stall = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && !in_stall) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, in_valid && !in_stall} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			buf_q[wr_q] <= in_req;
		end
	end
endmodule
`default_nettype wire

// ===== sv/hrc_engine.sv =====
// Back end: hashes, probes and clears the table memory and updates the statistics.
`default_nettype none
`include "hashed_result_cache_lru_defines.svh"
module hrc_engine import hrc_pkg::*; #(
	parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire req_t q_req,
	input wire logic cache_enabled,
	input wire logic [3:0] size_log2,
	output logic res_valid,
	input wire logic res_stall,
	output res_t res
);
	localparam int AW = MAX_SIZE_LOG2;
	localparam int DEPTH = 1 << AW;
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam int EW = 1 + 64 + 6 + 32 + 32;

	state_t state_q, state_d;
	req_t req_q;
	logic [63:0] h_q, lo_q;
	logic [31:0] x_q;
	logic [AW-1:0] mask_q, idx_q, victim_q, clr_q;
	logic [PW-1:0] probe_q;
	logic [31:0] oldest_q, clock_q;
	logic have_q;
	logic [31:0] hits_q, miss_q, ins_q, evc_q;
	logic hit_q, evicted_q;
	logic [31:0] found_q;

	logic we;
	logic [AW-1:0] addr;
	logic [EW-1:0] wdata, rdata;
	logic r_valid;
	logic [63:0] r_key;
	logic [5:0] r_cnt;
	logic [31:0] r_val, r_stamp;
	logic match, last_probe, clr_last;
	logic [4:0] s_sat;
	logic [63:0] m_lo;
	logic [63:0] mul_c;
	logic [31:0] cnt_mix;

	assign {r_valid, r_key, r_cnt, r_val, r_stamp} = rdata;
	assign match = r_valid && (r_cnt == req_q.key_count) && (r_key == req_q.key_mask);
	assign last_probe = (probe_q == PW'(PROBE_LIMIT - 1));
	assign clr_last = &clr_q;
	assign mul_c = (state_q == ST_H1 || state_q == ST_H2) ? MIX_C1 : MIX_C2;
	assign cnt_mix = {26'd0, req_q.key_count} * CNT_C[31:0];

	always_comb begin
		s_sat = {1'b0, size_log2};
		if (s_sat < 5'd1) begin
			s_sat = 5'd1;
		end
		if (s_sat > 5'(MAX_SIZE_LOG2)) begin
			s_sat = 5'(MAX_SIZE_LOG2);
		end
		m_lo = (64'd1 << s_sat) - 64'd1;
	end

	hrc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_H1;
				end
			end
			ST_H1: state_d = ST_H2;
			ST_H2: state_d = ST_H3;
			ST_H3: state_d = ST_H4;
			ST_H4: state_d = ST_H5;
			ST_H5: state_d = ST_H6;
			ST_H6: state_d = ST_H7;
			ST_H7: begin
				if ((req_q.op == OP_LOOKUP || req_q.op == OP_INSERT) && cache_enabled) begin
					state_d = ST_RD;
				end else if (req_q.op == OP_CLEAR) begin
					state_d = ST_CLR;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_RD: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_CHK;
			ST_CHK: begin
				if (req_q.op == OP_LOOKUP) begin
					if (!r_valid) begin
						state_d = ST_OUT;
					end else if (match) begin
						state_d = ST_WR;
					end else if (last_probe) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_RD;
					end
				end else if (!r_valid || match || last_probe) begin
					state_d = ST_WR;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_WR: state_d = ST_OUT;
			ST_CLR: begin
				if (clr_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		addr = idx_q;
		wdata = {1'b1, req_q.key_mask, req_q.key_count, req_q.insert_value, clock_q};
		q_pop = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_INIT, ST_CLR: begin
				we = 1'b1;
				addr = clr_q;
				wdata = '0;
			end
			ST_WR: begin
				we = 1'b1;
				if (req_q.op == OP_LOOKUP) begin
					wdata = {1'b1, r_key, r_cnt, r_val, clock_q};
				end else begin
					addr = victim_q;
				end
			end
			ST_OUT: res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	assign res.hit = hit_q;
	assign res.found_value = found_q;
	assign res.evicted = evicted_q;
	assign res.hit_total = hits_q;
	assign res.miss_total = miss_q;
	assign res.insert_total = ins_q;
	assign res.evict_total = evc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			clock_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			ins_q <= '0;
			evc_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_CLR) begin
				clock_q <= '0;
			end
			if (state_q == ST_H7 && req_q.op == OP_STATS) begin
				hits_q <= '0;
				miss_q <= '0;
				ins_q <= '0;
				evc_q <= '0;
			end
			if (state_q == ST_CHK) begin
				if (req_q.op == OP_LOOKUP) begin
					if (match) begin
						hits_q <= sat_inc(hits_q);
						clock_q <= clock_q + 32'd1;
					end else if (!r_valid || last_probe) begin
						miss_q <= sat_inc(miss_q);
					end
				end else if (!r_valid || match || last_probe) begin
					clock_q <= clock_q + 32'd1;
					if (!match) begin
						ins_q <= sat_inc(ins_q);
					end
					if (r_valid && !match) begin
						evc_q <= sat_inc(evc_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= q_req;
				h_q <= q_req.key_mask ^ (q_req.key_mask >> 33);
				hit_q <= 1'b0;
				found_q <= '0;
				evicted_q <= 1'b0;
				probe_q <= '0;
				have_q <= 1'b0;
				oldest_q <= '0;
			end
			ST_H1, ST_H4: begin
				lo_q <= mul32(h_q[31:0], mul_c[31:0]);
				x_q <= h_q[63:32] * mul_c[31:0];
			end
			ST_H2, ST_H5: h_q <= {lo_q[63:32] + x_q + h_q[31:0] * mul_c[63:32], lo_q[31:0]};
			ST_H3: h_q <= h_q ^ (h_q >> 33);
			ST_H6: h_q <= (h_q ^ (h_q >> 33)) ^ {32'd0, cnt_mix};
			ST_H7: begin
				mask_q <= m_lo[AW-1:0];
				idx_q <= h_q[AW-1:0] & m_lo[AW-1:0];
				victim_q <= h_q[AW-1:0] & m_lo[AW-1:0];
			end
			ST_CHK: begin
				if (req_q.op == OP_LOOKUP) begin
					if (match) begin
						hit_q <= 1'b1;
						found_q <= r_val;
					end else begin
						idx_q <= (idx_q + AW'(1)) & mask_q;
					end
				end else if (!r_valid || match) begin
					victim_q <= idx_q;
				end else begin
					if (!have_q || r_stamp < oldest_q) begin
						oldest_q <= r_stamp;
						victim_q <= idx_q;
						have_q <= 1'b1;
					end
					if (last_probe) begin
						evicted_q <= 1'b1;
					end
					idx_q <= (idx_q + AW'(1)) & mask_q;
				end
				probe_q <= probe_q + PW'(1);
			end
			default: begin
			end
		endcase
	end

	`HRC_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, state_q == ST_IDLE)
	`HRC_ASSERT_NEXT(a_out_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))
	`HRC_ASSERT_IMP(a_hit_lookup, clk, arst_n, res_valid && res.hit, req_q.op == OP_LOOKUP)
	`HRC_ASSERT_IMP(a_evict_ins, clk, arst_n, res_valid && res.evicted, req_q.op == OP_INSERT)
endmodule
`default_nettype wire

// ===== sv/hashed_result_cache_lru.sv =====
// Top level of the hashed result cache with least-recently-used eviction.
// A request is queued by the front end (two entries) and carried out by the engine one at a
// time: an idle state takes it, states H1 to H7 hash the key and form the slot index (each
// 64-bit multiply is built from 32-bit partial products in a multiply and an accumulate state),
// then a read, a wait and a check state per probed slot of the single-port table memory (up to
// PROBE_LIMIT probes), a write state on a hit or an insert and an output state that holds
// while the result is stalled. A disabled lookup or insert and a statistics reset skip the table.
// Clear writes all 2^MAX_SIZE_LOG2 table entries (4096 by default) empty, one per cycle.
// The same pass runs after reset before the first request is taken.
`default_nettype none
module hashed_result_cache_lru import hrc_pkg::*; #(
	parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] op,
	input wire logic [63:0] key_mask,
	input wire logic [5:0] key_count,
	input wire logic [31:0] insert_value,
	output logic out_valid,
	input wire logic out_stall,
	output logic hit,
	output logic [31:0] found_value,
	output logic evicted,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] insert_total,
	output logic [31:0] evict_total,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_pop;
	logic enable_q;
	logic [3:0] size_q;

	assign in_req = '{op: op, key_mask: key_mask, key_count: key_count,
		insert_value: insert_value};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			size_q <= 4'd12;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_SIZE: size_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	hrc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	hrc_engine #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .PROBE_LIMIT(PROBE_LIMIT)) u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.cache_enabled(enable_q), .size_log2(size_q), .res_valid(out_valid),
		.res_stall(out_stall), .res(res)
	);

	assign hit = res.hit;
	assign found_value = res.found_value;
	assign evicted = res.evicted;
	assign hit_total = res.hit_total;
	assign miss_total = res.miss_total;
	assign insert_total = res.insert_total;
	assign evict_total = res.evict_total;
endmodule
`default_nettype wire
